>>> src/assert_macros.svh
// Assertion macros used by the port-level checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define ASSERT_RST(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("%m: assertion failed");

// Check a property on every clock edge, reset included.
`define ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("%m: assertion failed");

`endif

>>> src/stp_pkg.sv
// Package with the payload types, command/status types and constants of the permutation unit.
`timescale 1ns / 1ps

package stp_pkg;

  typedef struct packed {
    logic [5:0] year_offset;
    logic [3:0] month;
    logic [4:0] day;
    logic [4:0] hour;
    logic [5:0] minute;
  } in_data_t;

  typedef struct packed {
    logic [4:0] shown_hour;
    logic [5:0] shown_minute;
  } out_data_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic load;
    logic seed_day;
    logic seed_hour;
    logic start_hour;
    logic start_min;
    logic sel_min;
    logic gen;
    logic rd;
    logic wr;
    logic commit;
    logic look;
    logic out_load;
  } cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic hour_rebuild;
    logic minute_rebuild;
    logic last;
  } status_t;

  localparam int          ADDR_W         = 3;
  localparam logic        REG_REF_YEAR   = 1'b0;
  localparam logic [11:0] REF_YEAR_RESET = 12'd2020;

  localparam logic [31:0] YEAR_SCALE  = 32'd10000;
  localparam logic [31:0] MONTH_SCALE = 32'd100;
  localparam logic [31:0] HOUR_SCALE  = 32'd100;

  localparam int XS_A = 13;
  localparam int XS_B = 17;
  localparam int XS_C = 5;

endpackage

>>> src/stp_ram.sv
// Generic single-write, single-read RAM with registered read-first output.
`timescale 1ns / 1ps

module stp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

>>> src/stp_ctrl.sv
// Controller state machine: sequences seeding, table rebuilds, lookup and result delivery.
`timescale 1ns / 1ps

module stp_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  output logic            out_valid,
  input  logic            out_stall,
  input  stp_pkg::status_t status,
  output stp_pkg::cmd_t    cmd
);

  import stp_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SEED_DAY,
    ST_SEED_HOUR,
    ST_CHK_H,
    ST_CHK_M,
    ST_GEN,
    ST_RD,
    ST_WR,
    ST_LOOK,
    ST_LOOK_OUT
  } state_t;

  state_t state_r;
  logic   sel_min_r;
  logic   out_valid_r;
  logic   out_free;

  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    cmd            = '0;
    cmd.load       = (state_r == ST_IDLE) && in_valid;
    cmd.seed_day   = (state_r == ST_SEED_DAY);
    cmd.seed_hour  = (state_r == ST_SEED_HOUR);
    cmd.start_hour = (state_r == ST_CHK_H) && status.hour_rebuild;
    cmd.start_min  = (state_r == ST_CHK_M) && status.minute_rebuild;
    cmd.sel_min    = sel_min_r;
    cmd.gen        = (state_r == ST_GEN);
    cmd.rd         = (state_r == ST_RD);
    cmd.wr         = (state_r == ST_WR);
    cmd.commit     = (state_r == ST_WR) && status.last;
    cmd.look       = (state_r == ST_LOOK) || (state_r == ST_LOOK_OUT);
    cmd.out_load   = (state_r == ST_LOOK_OUT) && out_free;
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      sel_min_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      // output register: load wins, otherwise drop once taken
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        ST_IDLE: begin
          if (in_valid) begin
            state_r <= ST_SEED_DAY;
          end
        end
        ST_SEED_DAY:  state_r <= ST_SEED_HOUR;
        ST_SEED_HOUR: state_r <= ST_CHK_H;
        ST_CHK_H: begin
          sel_min_r <= 1'b0;
          state_r   <= status.hour_rebuild ? ST_GEN : ST_CHK_M;
        end
        ST_CHK_M: begin
          sel_min_r <= 1'b1;
          state_r   <= status.minute_rebuild ? ST_GEN : ST_LOOK;
        end
        ST_GEN: state_r <= ST_RD;
        ST_RD:  state_r <= ST_WR;
        ST_WR: begin
          if (!status.last) begin
            state_r <= ST_RD;
          end else if (sel_min_r) begin
            state_r <= ST_LOOK;
          end else begin
            state_r <= ST_CHK_M;
          end
        end
        ST_LOOK: state_r <= ST_LOOK_OUT;
        ST_LOOK_OUT: begin
          if (out_free) begin
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

endmodule

>>> src/stp_dp.sv
// Datapath: seed arithmetic, held seeds, xorshift shuffle engine, table RAMs and result register.
`timescale 1ns / 1ps

module stp_dp #(
  parameter int HOUR_SLOTS   = 24,
  parameter int MINUTE_SLOTS = 60
) (
  input  logic               clk,
  input  logic               rst_n,
  input  stp_pkg::in_data_t  in_data,
  input  logic [11:0]        ref_year,
  input  stp_pkg::cmd_t      cmd,
  output stp_pkg::status_t   status,
  output stp_pkg::out_data_t out_data
);

  import stp_pkg::*;

  localparam int MAXS = (HOUR_SLOTS > MINUTE_SLOTS) ? HOUR_SLOTS : MINUTE_SLOTS;
  localparam int IW   = $clog2(MAXS);
  localparam int PW   = 33 + IW;
  localparam int HW   = $clog2(HOUR_SLOTS);
  localparam int MW   = $clog2(MINUTE_SLOTS);
  localparam logic [6:0]    HOUR_LIM = 7'(HOUR_SLOTS);
  localparam logic [6:0]    MIN_LIM  = 7'(MINUTE_SLOTS);
  localparam logic [IW-1:0] HOUR_LAST = IW'(HOUR_SLOTS - 1);
  localparam logic [IW-1:0] MIN_LAST  = IW'(MINUTE_SLOTS - 1);

  function automatic logic [31:0] xorshift(input logic [31:0] s);
    logic [31:0] t;
    t = s ^ (s << XS_A);
    t = t ^ (t >> XS_B);
    t = t ^ (t << XS_C);
    return t;
  endfunction

  // j = (s * cnt) >> 32, held at or below cnt - 1
  function automatic logic [IW-1:0] pick(input logic [31:0] s, input logic [IW:0] cnt);
    logic [PW-1:0] prod;
    logic [IW:0]   j;
    logic [IW:0]   idx;
    prod = PW'(s) * PW'(cnt);
    j    = prod[PW-1:32];
    idx  = cnt - (IW+1)'(1);
    if (j > idx) begin
      j = idx;
    end
    return j[IW-1:0];
  endfunction

  in_data_t      in_r;
  logic [31:0]   day_seed_r;
  logic [31:0]   hour_seed_r;
  logic [31:0]   hseed_r;
  logic [31:0]   mseed_r;
  logic          hvalid_r;
  logic          mvalid_r;
  logic [31:0]   s_r;
  logic [IW-1:0] i_r;
  logic [IW-1:0] j_r;
  out_data_t     out_r;

  logic [12:0]   year_sum;
  logic [31:0]   day_seed_nxt;
  logic [31:0]   s_adv;
  logic [IW:0]   cnt_gen;
  logic [IW:0]   cnt_wr;

  logic          h_we;
  logic [HW-1:0] h_waddr;
  logic [HW-1:0] h_wdata;
  logic [HW-1:0] h_raddr;
  logic [HW-1:0] h_rdata;
  logic          m_we;
  logic [MW-1:0] m_waddr;
  logic [MW-1:0] m_wdata;
  logic [MW-1:0] m_raddr;
  logic [MW-1:0] m_rdata;
  logic [IW-1:0] sel_rdata;
  logic          hr_ok;
  logic          mn_ok;

  assign year_sum     = {7'd0, in_r.year_offset} + {1'b0, ref_year};
  assign day_seed_nxt = 32'(year_sum) * YEAR_SCALE + 32'(in_r.month) * MONTH_SCALE
                        + 32'(in_r.day);
  assign s_adv        = xorshift(s_r);
  assign cnt_gen      = {1'b0, i_r} + (IW+1)'(1);
  assign cnt_wr       = {1'b0, i_r} + (IW+1)'(2);

  assign status.hour_rebuild   = !hvalid_r || (day_seed_r != hseed_r);
  assign status.minute_rebuild = !mvalid_r || (hour_seed_r != mseed_r);
  assign status.last           = (i_r == (cmd.sel_min ? MIN_LAST : HOUR_LAST));

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      in_r <= in_data;
    end
    if (cmd.seed_day) begin
      day_seed_r <= day_seed_nxt;
    end
    if (cmd.seed_hour) begin
      hour_seed_r <= day_seed_r * HOUR_SCALE + 32'(in_r.hour);
    end
    if (cmd.start_hour) begin
      s_r <= day_seed_r;
      i_r <= '0;
    end else if (cmd.start_min) begin
      s_r <= hour_seed_r;
      i_r <= '0;
    end else if (cmd.gen) begin
      s_r <= s_adv;
      j_r <= pick(s_adv, cnt_gen);
    end else if (cmd.wr) begin
      // advance to the next slot and draw its swap partner
      s_r <= s_adv;
      i_r <= i_r + IW'(1);
      j_r <= pick(s_adv, cnt_wr);
    end
    if (cmd.out_load) begin
      out_r <= {(hr_ok ? 5'(h_rdata) : 5'd0), (mn_ok ? 6'(m_rdata) : 6'd0)};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hseed_r  <= '0;
      mseed_r  <= '0;
      hvalid_r <= 1'b0;
      mvalid_r <= 1'b0;
    end else if (cmd.commit) begin
      if (cmd.sel_min) begin
        mseed_r  <= hour_seed_r;
        mvalid_r <= 1'b1;
      end else begin
        hseed_r  <= day_seed_r;
        hvalid_r <= 1'b1;
      end
    end
  end

  // Slot step: RD writes i at j and reads the old entry; WR moves it to i.
  assign sel_rdata = cmd.sel_min ? IW'(m_rdata) : IW'(h_rdata);

  always_comb begin
    h_we    = 1'b0;
    m_we    = 1'b0;
    h_waddr = HW'(j_r);
    m_waddr = MW'(j_r);
    h_wdata = HW'(i_r);
    m_wdata = MW'(i_r);
    if (cmd.rd) begin
      h_we = !cmd.sel_min;
      m_we = cmd.sel_min;
    end else if (cmd.wr) begin
      h_waddr = HW'(i_r);
      m_waddr = MW'(i_r);
      h_wdata = HW'(sel_rdata);
      m_wdata = MW'(sel_rdata);
      h_we    = !cmd.sel_min && (j_r != i_r);
      m_we    = cmd.sel_min && (j_r != i_r);
    end
  end

  assign h_raddr = cmd.look ? HW'(in_r.hour) : HW'(j_r);
  assign m_raddr = cmd.look ? MW'(in_r.minute) : MW'(j_r);
  assign hr_ok   = {2'd0, in_r.hour} < HOUR_LIM;
  assign mn_ok   = {1'd0, in_r.minute} < MIN_LIM;

  stp_ram #(
    .WIDTH (HW),
    .DEPTH (HOUR_SLOTS)
  ) u_hour_ram (
    .clk   (clk),
    .we    (h_we),
    .waddr (h_waddr),
    .wdata (h_wdata),
    .raddr (h_raddr),
    .rdata (h_rdata)
  );

  stp_ram #(
    .WIDTH (MW),
    .DEPTH (MINUTE_SLOTS)
  ) u_minute_ram (
    .clk   (clk),
    .we    (m_we),
    .waddr (m_waddr),
    .wdata (m_wdata),
    .raddr (m_raddr),
    .rdata (m_rdata)
  );

  assign out_data = out_r;

endmodule

>>> src/seeded_time_permutation_unit.sv
// Top level of the seeded time permutation unit: register port, controller and datapath.
`timescale 1ns / 1ps
// Usage:
//   Input channel (in_valid / in_stall / in_data): one date-and-time transaction is
//   taken when in_valid is high and in_stall low. in_stall stays high while an item
//   is being worked on; one item is in flight at a time.
//   Result channel (out_valid / out_stall / out_data): one result per input, held in
//   an output register until taken, so a new input can be taken while it waits.
//   An item steps through seeding, the hour and minute seed checks, a rebuild of
//   each table whose seed does not match, and the lookup before its result loads.
//   Each rebuild slot is done in the RD and WR steps on the single write port of
//   its table RAM: write i at j while reading the old entry, then move it to i.
//   The next input can be taken in the cycle after the result loads.
//   Register port (APB style, pready always high): reference_year at address 0.
//   Reset (synchronous, rst_n low): reference_year returns to 2020, both tables are
//   marked invalid so the first item rebuilds them; table contents are not cleared.
//   A stalled receiver holds the result; the block finishes its next item and waits.
module seeded_time_permutation_unit #(
  parameter int HOUR_SLOTS   = 24,
  parameter int MINUTE_SLOTS = 60
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  stp_pkg::in_data_t                 in_data,
  output logic                              out_valid,
  input  logic                              out_stall,
  output stp_pkg::out_data_t                out_data,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [stp_pkg::ADDR_W-1:0]        paddr,
  input  logic [31:0]                       pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready
);

  import stp_pkg::*;

  logic [11:0] ref_year_r;
  cmd_t        cmd;
  status_t     status;

  // Register port: write on the access phase, read back combinationally.
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_REF_YEAR) ? {20'd0, ref_year_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ref_year_r <= REF_YEAR_RESET;
    end else if (psel && penable && pwrite && pready && (paddr[2] == REG_REF_YEAR)) begin
      ref_year_r <= pwdata[11:0];
    end
  end

  // Sequencer: owns the handshakes and steps the datapath.
  stp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  // Seeds, shuffle engine, permutation tables and result register.
  stp_dp #(
    .HOUR_SLOTS   (HOUR_SLOTS),
    .MINUTE_SLOTS (MINUTE_SLOTS)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .ref_year (ref_year_r),
    .cmd      (cmd),
    .status   (status),
    .out_data (out_data)
  );

endmodule

>>> src/stp_checker.sv
// Port-level checker for the seeded time permutation unit, with its bind.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module stp_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input stp_pkg::out_data_t out_data
);

  // A taken transaction keeps the input side busy on the next cycle.
  `ASSERT_RST(a_busy_after_accept, clk, rst_n, in_valid && !in_stall |=> in_stall)
  // Reset empties the output register.
  `ASSERT_ALWAYS(a_reset_clears_out, clk, !rst_n |=> !out_valid)
  // A stalled result stays offered.
  `ASSERT_RST(a_out_hold, clk, rst_n, out_valid && out_stall |=> out_valid)
  // A stalled result keeps its payload.
  `ASSERT_RST(a_out_stable, clk, rst_n, out_valid && out_stall |=> $stable(out_data))

endmodule

bind seeded_time_permutation_unit stp_checker u_stp_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
